### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property with a synchronous reset that disables it.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked property that holds at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/core/rsc_pkg.sv
package rsc_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Width of the internal signed datapath.
  localparam int CALC_W = 18;

  // Action codes.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Rotation codes.
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_WIN_W  = 3'd0;
  localparam logic [2:0] REG_WIN_H  = 3'd1;
  localparam logic [2:0] REG_LOG_W  = 3'd2;
  localparam logic [2:0] REG_LOG_H  = 3'd3;
  localparam logic [2:0] REG_OFS_X  = 3'd4;
  localparam logic [2:0] REG_OFS_Y  = 3'd5;
  localparam logic [2:0] REG_ROT    = 3'd6;

  // One scissor rectangle in window pixels.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } rect_t;

  // Configuration values seen by the datapath.
  typedef struct packed {
    logic [12:0]        win_w;
    logic [12:0]        win_h;
    logic [12:0]        log_w;
    logic [12:0]        log_h;
    logic signed [12:0] ofs_x;
    logic signed [12:0] ofs_y;
    logic [1:0]         rot;
  } cfg_t;

endpackage

### rtl/core/rsc_clip.sv
module rsc_clip (
  input  rsc_pkg::cfg_t       cfg,
  input  logic signed [13:0]  pos_x,
  input  logic signed [13:0]  pos_y,
  input  logic [12:0]         size_w,
  input  logic [12:0]         size_h,
  input  logic                has_top,
  input  rsc_pkg::rect_t      top,
  output rsc_pkg::rect_t      rect
);

  logic signed [rsc_pkg::CALC_W-1:0] bx, by, bw, bh;
  logic signed [rsc_pkg::CALC_W-1:0] ww, wh, ox, oy, lw, lh;
  logic signed [rsc_pkg::CALC_W-1:0] rx, ry, rw, rh;
  logic signed [rsc_pkg::CALC_W-1:0] tx, ty, tr, tb;
  logic signed [rsc_pkg::CALC_W-1:0] right, bottom;
  logic signed [rsc_pkg::CALC_W-1:0] cx, cy, cw, ch;

  // Extend every operand into the common signed datapath.
  assign bx = rsc_pkg::CALC_W'(pos_x);
  assign by = rsc_pkg::CALC_W'(pos_y);
  assign ww = rsc_pkg::CALC_W'(cfg.win_w);
  assign wh = rsc_pkg::CALC_W'(cfg.win_h);
  assign lw = rsc_pkg::CALC_W'(cfg.log_w);
  assign lh = rsc_pkg::CALC_W'(cfg.log_h);
  assign ox = rsc_pkg::CALC_W'(cfg.ofs_x);
  assign oy = rsc_pkg::CALC_W'(cfg.ofs_y);
  assign tx = rsc_pkg::CALC_W'(top.x);
  assign ty = rsc_pkg::CALC_W'(top.y);
  assign tr = tx + rsc_pkg::CALC_W'(top.w);
  assign tb = ty + rsc_pkg::CALC_W'(top.h);

  // A zero size reaches to the logical screen edge.
  assign bw = (size_w == 13'd0) ? (lw - bx) : rsc_pkg::CALC_W'(size_w);
  assign bh = (size_h == 13'd0) ? (lh - by) : rsc_pkg::CALC_W'(size_h);

  // Map the logical box into window coordinates.
  always_comb begin
    unique case (cfg.rot)
      rsc_pkg::ROT_90: begin
        rx = ww - oy - by - bh;
        ry = ox + bx;
        rw = bh;
        rh = bw;
      end
      rsc_pkg::ROT_180: begin
        rx = ww - ox - bx - bw;
        ry = wh - oy - by - bh;
        rw = bw;
        rh = bh;
      end
      rsc_pkg::ROT_270: begin
        rx = oy + by;
        ry = wh - ox - bx - bw;
        rw = bh;
        rh = bw;
      end
      default: begin
        rx = ox + bx;
        ry = oy + by;
        rw = bw;
        rh = bh;
      end
    endcase
  end

  // Intersect with the current top, keeping the tighter edge on each side.
  always_comb begin
    right  = rx + rw;
    bottom = ry + rh;
    cx     = rx;
    cy     = ry;
    cw     = rw;
    ch     = rh;
    if (has_top) begin
      if (tx > rx) cx = tx;
      if (ty > ry) cy = ty;
      if (tr < right) right = tr;
      if (tb < bottom) bottom = tb;
      cw = right - cx;
      ch = bottom - cy;
    end
  end

  // Clamp negative sizes and narrow to the stored field widths.
  assign rect.x = cx[15:0];
  assign rect.y = cy[15:0];
  assign rect.w = (cw < 0) ? 15'd0 : cw[14:0];
  assign rect.h = (ch < 0) ? 15'd0 : ch[14:0];

endmodule

### rtl/core/rotated_scissor_clip_stack_core.sv
// Nested scissor rectangle stack with screen rotation.
// Input channel: an item (action, position, size) is transferred at a rising
// edge where start is high and busy is low. busy is low except during reset,
// so a new item may follow in every cycle.
// Result channel: every item yields one result, shown for exactly one cycle
// with out_strobe high. An item is captured in the input register, computed
// from it, lands in the result register and is transferred from there.
// The receiver cannot stall, so results are never held back and nothing
// queues inside the block.
// Throughput: one item per cycle. The top rectangle sits in its own
// register, so a push needs only adds and compares against it. The entry
// below the top is read ahead from the 16-entry stack array into a register
// at every edge, so a pop needs no array read of its own.
// Configuration: APB-style port, register i at byte address 4*i; the user
// writes it only while no item is in flight, which the block does not enforce.
// Reset (rst_n low at a clock edge) empties the stack, clears the
// configuration registers and drops any pending result. Stack entries
// themselves are not cleared; only entries below the count are read.
`include "assert_macros.svh"

module rotated_scissor_clip_stack_core (
  input  logic               clk,
  input  logic               rst_n,
  // Item input
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic signed [13:0] in_pos_x,
  input  logic signed [13:0] in_pos_y,
  input  logic [12:0]        in_size_w,
  input  logic [12:0]        in_size_h,
  // Result output
  output logic               out_strobe,
  output logic signed [15:0] out_scissor_x,
  output logic signed [15:0] out_scissor_y,
  output logic [14:0]        out_scissor_w,
  output logic [14:0]        out_scissor_h,
  output logic               out_underflow,
  output logic               out_overflow,
  output logic [4:0]         out_depth_now,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  rsc_pkg::cfg_t  cfg_r;
  logic [2:0]     reg_idx;
  logic           cfg_wr;

  logic               in_vld_r;
  logic               in_action_r;
  logic signed [13:0] in_pos_x_r, in_pos_y_r;
  logic [12:0]        in_size_w_r, in_size_h_r;

  rsc_pkg::rect_t stk_r [rsc_pkg::STACK_DEPTH];
  rsc_pkg::rect_t top_r, top_nxt;
  rsc_pkg::rect_t push_rect, pop_rect, res_rect, below_top_r;
  logic [rsc_pkg::CNT_W-1:0] cnt_r, cnt_nxt, pop_sum;
  logic [rsc_pkg::IDX_W-1:0] pop_idx, push_idx;
  logic           push_en, uf, ov;

  rsc_pkg::rect_t out_rect_r;
  logic           out_strobe_r, out_uf_r, out_ov_r;
  logic [rsc_pkg::CNT_W-1:0] out_cnt_r;

  // Configuration register file.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rsc_pkg::REG_WIN_W: cfg_r.win_w <= pwdata[12:0];
        rsc_pkg::REG_WIN_H: cfg_r.win_h <= pwdata[12:0];
        rsc_pkg::REG_LOG_W: cfg_r.log_w <= pwdata[12:0];
        rsc_pkg::REG_LOG_H: cfg_r.log_h <= pwdata[12:0];
        rsc_pkg::REG_OFS_X: cfg_r.ofs_x <= pwdata[12:0];
        rsc_pkg::REG_OFS_Y: cfg_r.ofs_y <= pwdata[12:0];
        rsc_pkg::REG_ROT:   cfg_r.rot   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      rsc_pkg::REG_WIN_W: prdata = 32'(cfg_r.win_w);
      rsc_pkg::REG_WIN_H: prdata = 32'(cfg_r.win_h);
      rsc_pkg::REG_LOG_W: prdata = 32'(cfg_r.log_w);
      rsc_pkg::REG_LOG_H: prdata = 32'(cfg_r.log_h);
      rsc_pkg::REG_OFS_X: prdata = 32'(unsigned'(cfg_r.ofs_x));
      rsc_pkg::REG_OFS_Y: prdata = 32'(unsigned'(cfg_r.ofs_y));
      rsc_pkg::REG_ROT:   prdata = 32'(cfg_r.rot);
      default:            prdata = '0;
    endcase
  end

  // Input register: one item per cycle.
  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_action_r <= in_action;
      in_pos_x_r  <= in_pos_x;
      in_pos_y_r  <= in_pos_y;
      in_size_w_r <= in_size_w;
      in_size_h_r <= in_size_h;
    end
  end

  // Map and clip a pushed box against the current top.
  rsc_clip u_clip (
    .cfg     (cfg_r),
    .pos_x   (in_pos_x_r),
    .pos_y   (in_pos_y_r),
    .size_w  (in_size_w_r),
    .size_h  (in_size_h_r),
    .has_top (cnt_r != '0),
    .top     (top_r),
    .rect    (push_rect)
  );

  // Entry that sits below the top once this item is done; it is read ahead
  // so that it is ready in a register for the next pop.
  assign pop_sum  = cnt_nxt - rsc_pkg::CNT_W'(2);
  assign pop_idx  = pop_sum[rsc_pkg::IDX_W-1:0];
  assign push_idx = cnt_r[rsc_pkg::IDX_W-1:0];
  assign pop_rect = below_top_r;

  // Stack control for the item in the input register.
  always_comb begin
    cnt_nxt  = cnt_r;
    top_nxt  = top_r;
    res_rect = top_r;
    push_en  = 1'b0;
    uf       = 1'b0;
    ov       = 1'b0;
    if (in_vld_r) begin
      if (in_action_r == rsc_pkg::ACT_POP) begin
        if (cnt_r == '0) begin
          uf       = 1'b1;
          res_rect = '0;
        end else begin
          cnt_nxt  = cnt_r - rsc_pkg::CNT_W'(1);
          top_nxt  = pop_rect;
          res_rect = pop_rect;
        end
      end else if (cnt_r == rsc_pkg::CNT_W'(rsc_pkg::STACK_DEPTH)) begin
        ov = 1'b1;
      end else begin
        push_en  = 1'b1;
        cnt_nxt  = cnt_r + rsc_pkg::CNT_W'(1);
        top_nxt  = push_rect;
        res_rect = push_rect;
      end
    end
  end

  // Stack storage; entries are valid only below the count.
  always_ff @(posedge clk) begin
    if (push_en) begin
      stk_r[push_idx] <= push_rect;
    end
    below_top_r <= (cnt_nxt >= rsc_pkg::CNT_W'(2)) ? stk_r[pop_idx] : '0;
    top_r      <= top_nxt;
    out_rect_r <= res_rect;
    out_uf_r   <= uf;
    out_ov_r   <= ov;
    out_cnt_r  <= cnt_nxt;
  end

  // Count and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      out_strobe_r <= in_vld_r;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_scissor_x = out_rect_r.x;
  assign out_scissor_y = out_rect_r.y;
  assign out_scissor_w = out_rect_r.w;
  assign out_scissor_h = out_rect_r.h;
  assign out_underflow = out_uf_r;
  assign out_overflow  = out_ov_r;
  assign out_depth_now = 5'(out_cnt_r);

  // Checks.
  `ASSERT_RST(a_item_gets_result, clk, rst_n, (start && !busy) |=> ##1 out_strobe)
  `ASSERT_RST(a_count_bound, clk, rst_n, cnt_r <= rsc_pkg::CNT_W'(rsc_pkg::STACK_DEPTH))
  `ASSERT_RST(a_ovf_full, clk, rst_n,
              (out_strobe && out_overflow) |-> (out_depth_now == 5'(rsc_pkg::STACK_DEPTH)))
  `ASSERT_RST(a_udf_empty, clk, rst_n,
              (out_strobe && out_underflow) |-> (out_depth_now == 5'd0 && out_scissor_w == 15'd0))

endmodule
